// ===== src/acs_pkg.sv =====
// ----------------------------------------------------------------------------
// acs_pkg: shared types and constants
// Word and address sizes, opcodes, result codes and the command and status
// structs that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package acs_pkg;

    localparam int MemDepth  = 1024;
    localparam int WordWidth = 32;
    localparam int AddrWidth = $clog2(MemDepth);
    localparam int CntWidth  = $clog2(WordWidth + 1);

    typedef logic [WordWidth-1:0] word_t;
    typedef logic [AddrWidth-1:0] addr_t;

    typedef enum logic [1:0] {
        CMD_WRITE   = 2'd0,
        CMD_EXEC    = 2'd1,
        CMD_RESTART = 2'd2
    } item_cmd_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_STOPPED = 3'd1,
        ST_DIVZERO = 3'd2,
        ST_INVALID = 3'd3,
        ST_HALTED  = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        OP_BAD    = 4'd0,
        OP_ADD    = 4'd1,
        OP_SUB    = 4'd2,
        OP_MULT   = 4'd3,
        OP_DIV    = 4'd4,
        OP_JMP    = 4'd5,
        OP_JMPN   = 4'd6,
        OP_JMPP   = 4'd7,
        OP_JMPZ   = 4'd8,
        OP_COPY   = 4'd9,
        OP_LOAD   = 4'd10,
        OP_STORE  = 4'd11,
        OP_INPUT  = 4'd12,
        OP_OUTPUT = 4'd13,
        OP_STOP   = 4'd14
    } opcode_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_FETCH_A,
        S_FETCH_M,
        S_FETCH_B,
        S_EXEC,
        S_DIV_WAIT,
        S_RESULT
    } state_t;

    typedef enum logic [1:0] {
        RA_PC,
        RA_PC1,
        RA_RDATA,
        RA_PC2
    } raddr_sel_t;

    typedef enum logic [1:0] {
        WS_ITEM,
        WS_ACC,
        WS_INPUT,
        WS_COPY
    } wsel_t;

    typedef enum logic [2:0] {
        ACC_KEEP,
        ACC_ADD,
        ACC_SUB,
        ACC_MUL,
        ACC_DIV,
        ACC_LOAD,
        ACC_CLEAR
    } acc_sel_t;

    typedef enum logic [2:0] {
        PC_KEEP,
        PC_STEP2,
        PC_STEP3,
        PC_JUMP,
        PC_CLEAR
    } pc_sel_t;

    typedef struct packed {
        logic       ld_item;
        raddr_sel_t raddr_sel;
        logic       lat_op;
        logic       lat_a;
        logic       lat_m;
        logic       mem_we;
        wsel_t      wsel;
        acc_sel_t   acc_sel;
        pc_sel_t    pc_sel;
        logic       halt_set;
        logic       halt_clr;
        logic       div_start;
        logic       res_set;
        status_t    res_status;
        logic       res_outv;
        logic       res_iused;
        logic       out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        item_cmd_t item_cmd;
        logic      halted;
        opcode_t   op;
        logic      m_zero;
        logic      acc_neg;
        logic      acc_zero;
        logic      div_done;
    } dp_stat_t;

endpackage

// ===== src/accumulator_cpu_step_top.sv =====
// ----------------------------------------------------------------------------
// accumulator_cpu_step_top: accumulator machine, one step per beat
// Each input beat writes a memory word, restarts the machine or executes
// one instruction; each gives exactly one result beat.
//
//   channel  direction  signals
//   in       sink       in_valid, in_ready, cmd, address, data, input_value
//   out      source     out_valid, out_ready, status, next_pc, acc_value,
//                       output_valid, output_value, input_used
//
// write, restart, unused command and halted execute: decode, then result
// execute: decode, fetch A, M and B, exec, result; DIV with nonzero divisor
// waits on the divider; the single memory read port (four reads) sets cost
// reset clears pc, accumulator, halted and the handshake; memory is not
// cleared. a stalled out channel holds the sequencer before returning to idle
// ----------------------------------------------------------------------------
module accumulator_cpu_step_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         cmd,
    input  logic [9:0]         address,
    input  logic signed [31:0] data,
    input  logic signed [31:0] input_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         status,
    output logic [9:0]         next_pc,
    output logic signed [31:0] acc_value,
    output logic               output_valid,
    output logic signed [31:0] output_value,
    output logic               input_used
);

    acs_pkg::ctrl_cmd_t ctl;
    acs_pkg::dp_stat_t  stat;

    acs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    acs_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .stat         (stat),
        .cmd          (cmd),
        .address      (address),
        .data         (data),
        .input_value  (input_value),
        .status       (status),
        .next_pc      (next_pc),
        .acc_value    (acc_value),
        .output_valid (output_valid),
        .output_value (output_value),
        .input_used   (input_used)
    );

endmodule

// ===== src/acs_div.sv =====
// ----------------------------------------------------------------------------
// acs_div: iterative signed divider
// Restoring divide on magnitudes, one quotient bit per cycle, quotient
// truncated toward zero and sign fixed at the output.
// ----------------------------------------------------------------------------
module acs_div (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  acs_pkg::word_t dividend,
    input  acs_pkg::word_t divisor,
    output logic           done,
    output acs_pkg::word_t quotient
);

    localparam int W = acs_pkg::WordWidth;

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [acs_pkg::CntWidth-1:0]  cnt_reg, cnt_next;
    logic [W:0]                    rem_reg;
    logic [W-1:0]                  quo_reg;
    logic [W-1:0]                  den_reg;
    logic                          neg_reg;

    logic [W:0]   rem_sh;
    logic [W:0]   diff;
    logic         ge;
    logic [W-1:0] mag_n;
    logic [W-1:0] mag_d;

    assign mag_n  = dividend[W-1] ? (W'(0) - dividend) : dividend;
    assign mag_d  = divisor[W-1]  ? (W'(0) - divisor)  : divisor;
    assign rem_sh = {rem_reg[W-1:0], quo_reg[W-1]};
    assign diff   = rem_sh - {1'b0, den_reg};
    assign ge     = !diff[W];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = acs_pkg::CntWidth'(W);
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == acs_pkg::CntWidth'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= mag_n;
            den_reg <= mag_d;
            neg_reg <= dividend[W-1] ^ divisor[W-1];
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff : rem_sh;
            quo_reg <= {quo_reg[W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (W'(0) - quo_reg) : quo_reg;

endmodule

// ===== src/acs_datapath.sv =====
// ----------------------------------------------------------------------------
// acs_datapath: machine registers, word memory and arithmetic
// Holds pc, accumulator, halted flag, the word memory with a registered
// read port, the divider and the result payload registers.
// ----------------------------------------------------------------------------
module acs_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  acs_pkg::ctrl_cmd_t  ctl,
    output acs_pkg::dp_stat_t   stat,
    input  logic [1:0]          cmd,
    input  logic [9:0]          address,
    input  logic signed [31:0]  data,
    input  logic signed [31:0]  input_value,
    output logic [2:0]          status,
    output logic [9:0]          next_pc,
    output logic signed [31:0]  acc_value,
    output logic                output_valid,
    output logic signed [31:0]  output_value,
    output logic                input_used
);

    localparam int W  = acs_pkg::WordWidth;
    localparam int AW = acs_pkg::AddrWidth;

    acs_pkg::word_t mem [acs_pkg::MemDepth];

    logic [1:0]      item_cmd_reg;
    logic [9:0]      item_addr_reg;
    logic [31:0]     item_data_reg;
    logic [31:0]     item_in_reg;
    acs_pkg::word_t  rdata_reg;
    acs_pkg::word_t  op_reg;
    acs_pkg::word_t  a_reg;
    acs_pkg::word_t  m_reg;
    acs_pkg::word_t  acc_reg, acc_next;
    acs_pkg::addr_t  pc_reg, pc_next;
    logic            halted_reg;
    acs_pkg::status_t res_status_reg;
    logic            res_outv_reg;
    logic            res_iused_reg;

    logic [2:0]      out_status_reg;
    logic [9:0]      out_pc_reg;
    logic [31:0]     out_acc_reg;
    logic            out_outv_reg;
    logic [31:0]     out_oval_reg;
    logic            out_iused_reg;

    acs_pkg::addr_t  raddr;
    acs_pkg::addr_t  waddr;
    acs_pkg::word_t  wdata;
    acs_pkg::word_t  quotient;
    logic            div_done;

    acs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.div_start),
        .dividend (acc_reg),
        .divisor  (m_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb
    begin
        unique case (ctl.raddr_sel)
            acs_pkg::RA_PC:    raddr = pc_reg;
            acs_pkg::RA_PC1:   raddr = pc_reg + AW'(1);
            acs_pkg::RA_RDATA: raddr = rdata_reg[AW-1:0];
            acs_pkg::RA_PC2:   raddr = pc_reg + AW'(2);
            default:           raddr = pc_reg;
        endcase
    end

    always_comb
    begin
        unique case (ctl.wsel)
            acs_pkg::WS_ITEM:
            begin
                waddr = AW'(item_addr_reg);
                wdata = W'($signed(item_data_reg));
            end
            acs_pkg::WS_ACC:
            begin
                waddr = a_reg[AW-1:0];
                wdata = acc_reg;
            end
            acs_pkg::WS_INPUT:
            begin
                waddr = a_reg[AW-1:0];
                wdata = W'($signed(item_in_reg));
            end
            acs_pkg::WS_COPY:
            begin
                // copy destination is the third word, still on the read port
                waddr = rdata_reg[AW-1:0];
                wdata = m_reg;
            end
            default:
            begin
                waddr = a_reg[AW-1:0];
                wdata = acc_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.mem_we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_comb
    begin
        unique case (ctl.acc_sel)
            acs_pkg::ACC_KEEP:  acc_next = acc_reg;
            acs_pkg::ACC_ADD:   acc_next = acc_reg + m_reg;
            acs_pkg::ACC_SUB:   acc_next = acc_reg - m_reg;
            acs_pkg::ACC_MUL:   acc_next = acc_reg * m_reg;
            acs_pkg::ACC_DIV:   acc_next = quotient;
            acs_pkg::ACC_LOAD:  acc_next = m_reg;
            acs_pkg::ACC_CLEAR: acc_next = '0;
            default:            acc_next = acc_reg;
        endcase
    end

    always_comb
    begin
        unique case (ctl.pc_sel)
            acs_pkg::PC_KEEP:  pc_next = pc_reg;
            acs_pkg::PC_STEP2: pc_next = pc_reg + AW'(2);
            acs_pkg::PC_STEP3: pc_next = pc_reg + AW'(3);
            acs_pkg::PC_JUMP:  pc_next = a_reg[AW-1:0];
            acs_pkg::PC_CLEAR: pc_next = '0;
            default:           pc_next = pc_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg    <= '0;
            pc_reg     <= '0;
            halted_reg <= 1'b0;
        end
        else
        begin
            acc_reg <= acc_next;
            pc_reg  <= pc_next;
            if (ctl.halt_clr)
            begin
                halted_reg <= 1'b0;
            end
            else if (ctl.halt_set)
            begin
                halted_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ld_item)
        begin
            item_cmd_reg  <= cmd;
            item_addr_reg <= address;
            item_data_reg <= data;
            item_in_reg   <= input_value;
        end
        if (ctl.lat_op)
        begin
            op_reg <= rdata_reg;
        end
        if (ctl.lat_a)
        begin
            a_reg <= rdata_reg;
        end
        if (ctl.lat_m)
        begin
            m_reg <= rdata_reg;
        end
        if (ctl.res_set)
        begin
            res_status_reg <= ctl.res_status;
            res_outv_reg   <= ctl.res_outv;
            res_iused_reg  <= ctl.res_iused;
        end
        if (ctl.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_pc_reg     <= 10'(pc_reg);
            out_acc_reg    <= 32'(acc_reg);
            out_outv_reg   <= res_outv_reg;
            out_oval_reg   <= res_outv_reg ? 32'(m_reg) : 32'd0;
            out_iused_reg  <= res_iused_reg;
        end
    end

    always_comb
    begin
        stat.item_cmd = acs_pkg::item_cmd_t'(item_cmd_reg);
        stat.halted   = halted_reg;
        stat.op       = (op_reg[W-1:4] == '0) ? acs_pkg::opcode_t'(op_reg[3:0])
                                              : acs_pkg::OP_BAD;
        stat.m_zero   = (m_reg == '0);
        stat.acc_neg  = acc_reg[W-1];
        stat.acc_zero = (acc_reg == '0);
        stat.div_done = div_done;
    end

    assign status       = out_status_reg;
    assign next_pc      = out_pc_reg;
    assign acc_value    = out_acc_reg;
    assign output_valid = out_outv_reg;
    assign output_value = out_oval_reg;
    assign input_used   = out_iused_reg;

endmodule

// ===== src/acs_ctrl.sv =====
// ----------------------------------------------------------------------------
// acs_ctrl: instruction sequencer
// Takes one beat, walks fetch, operand read, execute and divide wait, and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module acs_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  acs_pkg::dp_stat_t  stat,
    output acs_pkg::ctrl_cmd_t ctl
);

    acs_pkg::state_t state_reg, state_next;
    logic            out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= acs_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        in_ready       = 1'b0;
        ctl            = '0;
        ctl.raddr_sel  = acs_pkg::RA_PC;
        ctl.wsel       = acs_pkg::WS_ITEM;
        ctl.acc_sel    = acs_pkg::ACC_KEEP;
        ctl.pc_sel     = acs_pkg::PC_KEEP;
        ctl.res_status = acs_pkg::ST_OK;
        out_valid_next = out_valid_reg && !out_ready;

        unique case (state_reg)
            acs_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.ld_item = 1'b1;
                    state_next  = acs_pkg::S_DECODE;
                end
            end

            acs_pkg::S_DECODE:
            begin
                ctl.res_set    = 1'b1;
                ctl.raddr_sel  = acs_pkg::RA_PC;
                state_next     = acs_pkg::S_RESULT;
                unique case (stat.item_cmd)
                    acs_pkg::CMD_WRITE:
                    begin
                        ctl.mem_we = 1'b1;
                        ctl.wsel   = acs_pkg::WS_ITEM;
                    end
                    acs_pkg::CMD_RESTART:
                    begin
                        ctl.pc_sel   = acs_pkg::PC_CLEAR;
                        ctl.acc_sel  = acs_pkg::ACC_CLEAR;
                        ctl.halt_clr = 1'b1;
                    end
                    acs_pkg::CMD_EXEC:
                    begin
                        if (stat.halted)
                        begin
                            ctl.res_status = acs_pkg::ST_HALTED;
                        end
                        else
                        begin
                            ctl.res_set = 1'b0;
                            state_next  = acs_pkg::S_FETCH_A;
                        end
                    end
                    default:
                    begin
                        // unused command code: no change, status ok
                    end
                endcase
            end

            acs_pkg::S_FETCH_A:
            begin
                ctl.lat_op    = 1'b1;
                ctl.raddr_sel = acs_pkg::RA_PC1;
                state_next    = acs_pkg::S_FETCH_M;
            end

            acs_pkg::S_FETCH_M:
            begin
                ctl.lat_a     = 1'b1;
                ctl.raddr_sel = acs_pkg::RA_RDATA;
                state_next    = acs_pkg::S_FETCH_B;
            end

            acs_pkg::S_FETCH_B:
            begin
                ctl.lat_m     = 1'b1;
                ctl.raddr_sel = acs_pkg::RA_PC2;
                state_next    = acs_pkg::S_EXEC;
            end

            acs_pkg::S_EXEC:
            begin
                ctl.res_set = 1'b1;
                state_next  = acs_pkg::S_RESULT;
                ctl.pc_sel  = acs_pkg::PC_STEP2;
                unique case (stat.op)
                    acs_pkg::OP_ADD:  ctl.acc_sel = acs_pkg::ACC_ADD;
                    acs_pkg::OP_SUB:  ctl.acc_sel = acs_pkg::ACC_SUB;
                    acs_pkg::OP_MULT: ctl.acc_sel = acs_pkg::ACC_MUL;
                    acs_pkg::OP_LOAD: ctl.acc_sel = acs_pkg::ACC_LOAD;
                    acs_pkg::OP_DIV:
                    begin
                        if (stat.m_zero)
                        begin
                            ctl.pc_sel     = acs_pkg::PC_KEEP;
                            ctl.res_status = acs_pkg::ST_DIVZERO;
                            ctl.halt_set   = 1'b1;
                        end
                        else
                        begin
                            ctl.pc_sel    = acs_pkg::PC_KEEP;
                            ctl.res_set   = 1'b0;
                            ctl.div_start = 1'b1;
                            state_next    = acs_pkg::S_DIV_WAIT;
                        end
                    end
                    acs_pkg::OP_JMP:  ctl.pc_sel = acs_pkg::PC_JUMP;
                    acs_pkg::OP_JMPN:
                    begin
                        if (stat.acc_neg)
                        begin
                            ctl.pc_sel = acs_pkg::PC_JUMP;
                        end
                    end
                    acs_pkg::OP_JMPP:
                    begin
                        if (!stat.acc_neg && !stat.acc_zero)
                        begin
                            ctl.pc_sel = acs_pkg::PC_JUMP;
                        end
                    end
                    acs_pkg::OP_JMPZ:
                    begin
                        if (stat.acc_zero)
                        begin
                            ctl.pc_sel = acs_pkg::PC_JUMP;
                        end
                    end
                    acs_pkg::OP_COPY:
                    begin
                        ctl.mem_we = 1'b1;
                        ctl.wsel   = acs_pkg::WS_COPY;
                        ctl.pc_sel = acs_pkg::PC_STEP3;
                    end
                    acs_pkg::OP_STORE:
                    begin
                        ctl.mem_we = 1'b1;
                        ctl.wsel   = acs_pkg::WS_ACC;
                    end
                    acs_pkg::OP_INPUT:
                    begin
                        ctl.mem_we    = 1'b1;
                        ctl.wsel      = acs_pkg::WS_INPUT;
                        ctl.res_iused = 1'b1;
                    end
                    acs_pkg::OP_OUTPUT: ctl.res_outv = 1'b1;
                    acs_pkg::OP_STOP:
                    begin
                        ctl.pc_sel     = acs_pkg::PC_KEEP;
                        ctl.res_status = acs_pkg::ST_STOPPED;
                        ctl.halt_set   = 1'b1;
                    end
                    default:
                    begin
                        ctl.pc_sel     = acs_pkg::PC_KEEP;
                        ctl.res_status = acs_pkg::ST_INVALID;
                        ctl.halt_set   = 1'b1;
                    end
                endcase
            end

            acs_pkg::S_DIV_WAIT:
            begin
                if (stat.div_done)
                begin
                    ctl.acc_sel = acs_pkg::ACC_DIV;
                    ctl.pc_sel  = acs_pkg::PC_STEP2;
                    ctl.res_set = 1'b1;
                    state_next  = acs_pkg::S_RESULT;
                end
            end

            acs_pkg::S_RESULT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    ctl.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = acs_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = acs_pkg::S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule
